// ----- sv/q31_newton_raphson_divider_assert.svh -----
// ----------------------------------------------------------------------------
// Q31 Newton-Raphson divider assertion macros
// Shared concurrent assertion forms, clocked by i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef Q31_NEWTON_RAPHSON_DIVIDER_ASSERT_SVH
`define Q31_NEWTON_RAPHSON_DIVIDER_ASSERT_SVH

`define Q31NR_ASSERT_SAME(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (prop)) else $error(msg);

`define Q31NR_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (prop)) else $error(msg);

`endif

// ----- sv/q31nr_pkg.sv -----
// ----------------------------------------------------------------------------
// Q31 Newton-Raphson divider package
// Payload types, fixed-point constants and arithmetic helpers.
// ----------------------------------------------------------------------------
package q31nr_pkg;

    localparam int REFINE_STEPS_DEF = 3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NUM_GT   = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;

    localparam logic signed [31:0] C1_Q29  = 32'sd252645135;
    localparam logic signed [31:0] C2_Q29  = 32'sd378967702;
    localparam logic signed [31:0] ONE_Q29 = 32'sd536870911;
    localparam logic [30:0]        MASK31  = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [30:0] numerator;
        logic [30:0] denominator;
    } t_in;

    typedef struct packed {
        logic [30:0] quotient;
        logic [1:0]  status;
    } t_out;

    function automatic logic signed [63:0] mul32(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] aa;
        logic signed [63:0] bb;
        aa = a;
        bb = b;
        return aa * bb;
    endfunction

    function automatic logic signed [63:0] rnd_q29(input logic signed [63:0] p);
        return (p + 64'sd268435456) >>> 29;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = signed'(v[31:0]);
        end
        return r;
    endfunction

    function automatic logic [4:0] lzc31(input logic [30:0] v);
        logic [4:0] lz;
        lz = 5'd0;
        for (int i = 0; i < 31; i++) begin
            if (v[i]) begin
                lz = 5'(30 - i);
            end
        end
        return lz;
    endfunction

endpackage

// ----- sv/q31_newton_raphson_divider.sv -----
// Stage order: input, classify, normalize, seed, refinement, final multiply, final round.
// Throughput: one division per cycle unless stalled; each multiply, round/add owns a stage.
// A stalled output holds the full stages up to the nearest bubble; bubbles keep filling.
// Reset clears the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// Q31 Newton-Raphson divider
// Pipelined Q31 fraction divider: classify, normalize, seed, refine the reciprocal, multiply.
// ----------------------------------------------------------------------------
module q31_newton_raphson_divider
    import q31nr_pkg::*;
#(
    parameter int REFINE_STEPS = REFINE_STEPS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int NST  = 7 + 4 * REFINE_STEPS;
    localparam int REF0 = 5;

    typedef struct packed {
        logic               sp;
        logic [30:0]        sq;
        logic [1:0]         st;
        logic [30:0]        num;
        logic [30:0]        den;
        logic [4:0]         lz;
        logic [28:0]        n;
        logic [28:0]        d;
        logic signed [31:0] x;
        logic signed [31:0] e;
        logic signed [63:0] p;
    } t_stage;

    t_stage       r_st [NST];
    t_stage       n_st [NST];
    logic [NST-1:0] r_v;
    logic [NST:0]   en;

    assign en[NST] = !i_out_stall;

    genvar gi;
    generate
        for (gi = 0; gi < NST; gi++) begin : g_stage
            assign en[gi] = !r_v[gi] || en[gi+1];

            if (gi == 0) begin : g_in
                always_comb begin
                    n_st[gi]     = '0;
                    n_st[gi].num = i_in_data.numerator;
                    n_st[gi].den = i_in_data.denominator;
                end
            end else if (gi == 1) begin : g_class
                always_comb begin
                    n_st[gi]    = r_st[gi-1];
                    n_st[gi].lz = lzc31(r_st[gi-1].den);
                    n_st[gi].sq = '0;
                    n_st[gi].st = ST_OK;
                    n_st[gi].sp = 1'b1;
                    if (r_st[gi-1].num > r_st[gi-1].den) begin
                        n_st[gi].st = ST_NUM_GT;
                    end else if (r_st[gi-1].den == '0) begin
                        n_st[gi].st = ST_DIV_ZERO;
                    end else if (r_st[gi-1].num == r_st[gi-1].den) begin
                        n_st[gi].sq = MASK31;
                    end else begin
                        n_st[gi].sp = 1'b0;
                    end
                end
            end else if (gi == 2) begin : g_norm
                logic [30:0] den_sh;
                logic [30:0] num_sh;
                assign den_sh = r_st[gi-1].den << r_st[gi-1].lz;
                assign num_sh = r_st[gi-1].num << r_st[gi-1].lz;
                always_comb begin
                    n_st[gi]   = r_st[gi-1];
                    n_st[gi].d = den_sh[30:2];
                    n_st[gi].n = num_sh[30:2];
                end
            end else if (gi == 3) begin : g_seed_mul
                always_comb begin
                    n_st[gi]   = r_st[gi-1];
                    n_st[gi].p = mul32(C1_Q29, signed'({3'b000, r_st[gi-1].d}));
                end
            end else if (gi == 4) begin : g_seed_add
                logic signed [31:0] s0;
                assign s0 = sat32(64'(C2_Q29) - rnd_q29(r_st[gi-1].p));
                always_comb begin
                    n_st[gi]   = r_st[gi-1];
                    n_st[gi].x = sat32(64'(s0) <<< 2);
                end
            end else if (gi < REF0 + 4 * REFINE_STEPS) begin : g_refine
                localparam int PH = (gi - REF0) % 4;
                always_comb begin
                    n_st[gi] = r_st[gi-1];
                    case (PH)
                        0: n_st[gi].p = mul32(signed'({3'b000, r_st[gi-1].d}), r_st[gi-1].x);
                        1: n_st[gi].e = sat32(64'(ONE_Q29) - rnd_q29(r_st[gi-1].p));
                        2: n_st[gi].p = mul32(r_st[gi-1].x, r_st[gi-1].e);
                        default: n_st[gi].x = sat32(64'(r_st[gi-1].x) + rnd_q29(r_st[gi-1].p));
                    endcase
                end
            end else if (gi == NST - 2) begin : g_final_mul
                always_comb begin
                    n_st[gi]   = r_st[gi-1];
                    n_st[gi].p = mul32(signed'({3'b000, r_st[gi-1].n}), r_st[gi-1].x);
                end
            end else begin : g_final_rnd
                logic signed [63:0] r;
                assign r = (r_st[gi-1].p + 64'sd67108864) >>> 27;
                always_comb begin
                    n_st[gi] = r_st[gi-1];
                    if (!r_st[gi-1].sp) begin
                        if (r < 0) begin
                            n_st[gi].sq = '0;
                        end else if (r > 64'sd2147483647) begin
                            n_st[gi].sq = MASK31;
                        end else begin
                            n_st[gi].sq = r[30:0];
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[gi] <= 1'b0;
                end else if (en[gi]) begin
                    r_v[gi] <= (gi == 0) ? i_in_valid : r_v[(gi == 0) ? 0 : gi - 1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en[gi]) begin
                    r_st[gi] <= n_st[gi];
                end
            end
        end
    endgenerate

    assign o_in_stall           = !en[0];
    assign o_out_valid          = r_v[NST-1];
    assign o_out_data.quotient  = r_st[NST-1].sq;
    assign o_out_data.status    = r_st[NST-1].st;

`include "q31_newton_raphson_divider_assert.svh"

    `Q31NR_ASSERT_SAME(a_free_out_takes_in, !i_out_stall, !o_in_stall, "input stalled with free output")
    `Q31NR_ASSERT_SAME(a_bubble_takes_in, !r_v[0], !o_in_stall, "input stalled over an empty stage")
    `Q31NR_ASSERT_SAME(a_norm_d, r_v[2] && !r_st[2].sp, r_st[2].d[28], "denominator not normalized")
    `Q31NR_ASSERT_NEXT(a_held_out, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_data) && (!i_out_stall || (o_in_stall == (&r_v))),
        "stalled result lost or stall mismatch")

endmodule

// ----- tb/q31_newton_raphson_divider_test.sv -----
// ----------------------------------------------------------------------------
// Q31 Newton-Raphson divider testbench
// Drives a table of edge-case divisions and then about fourteen hundred random
// ones through the valid/stall channels, with random gaps on the input side and
// random stalls on the output side. One phase holds the output off long enough
// for the pipeline to fill. Every result is checked field by field against an
// in-order queue of results from the table or a bit-accurate fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module q31_newton_raphson_divider_test;
    import q31nr_pkg::*;

    localparam int          REFINE_PASSES  = 3;
    localparam longint      RECIP_SLOPE    = 64'sd252645135;
    localparam longint      RECIP_OFFSET   = 64'sd378967702;
    localparam longint      UNITY_Q29      = 64'sd536870911;
    localparam logic [30:0] Q31_MAX        = 31'h7FFF_FFFF;
    localparam int          QUIET_LIMIT    = 2000;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          PHASE_ITEMS    = 340;
    localparam int          PRESSURE_ITEMS = 80;
    localparam int          DRAIN_CYCLES   = 40;
    localparam int          IDLE_PLAN [4]  = '{0, 48, 0, 34};
    localparam int          STALL_PLAN [4] = '{0, 0, 48, 34};

    typedef struct {
        t_in  op;
        bit   known;
        t_out res;
    } t_row;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    t_out quot_expected [$];
    t_out quot_head;
    int   mismatches    = 0;
    int   idle_pct      = 0;
    int   stall_pct     = 0;
    int   hold_requests = 0;
    int   hold_served   = 0;
    int   hold_left     = 0;
    int   quiet_cycles  = 0;

    t_row directed_rows [22] = '{
        '{'{31'd0, 31'd0}, 1'b1, '{31'd0, ST_DIV_ZERO}},
        '{'{31'd1, 31'd0}, 1'b1, '{31'd0, ST_NUM_GT}},
        '{'{Q31_MAX, 31'd0}, 1'b1, '{31'd0, ST_NUM_GT}},
        '{'{Q31_MAX, 31'h7FFF_FFFE}, 1'b1, '{31'd0, ST_NUM_GT}},
        '{'{31'd2, 31'd1}, 1'b1, '{31'd0, ST_NUM_GT}},
        '{'{Q31_MAX, Q31_MAX}, 1'b1, '{Q31_MAX, ST_OK}},
        '{'{31'd1, 31'd1}, 1'b1, '{Q31_MAX, ST_OK}},
        '{'{31'h4000_0000, 31'h4000_0000}, 1'b1, '{Q31_MAX, ST_OK}},
        '{'{31'd0, 31'd1}, 1'b0, '{31'd0, ST_OK}},
        '{'{31'd0, Q31_MAX}, 1'b0, '{31'd0, ST_OK}},
        '{'{31'd1, 31'd2}, 1'b0, '{31'd0, ST_OK}},
        '{'{31'h7FFF_FFFE, Q31_MAX}, 1'b0, '{31'd0, ST_OK}},
        '{'{31'h3FFF_FFFF, 31'h4000_0000}, 1'b0, '{31'd0, ST_OK}},
        '{'{31'h1FFF_FFFF, 31'h2000_0000}, 1'b0, '{31'd0, ST_OK}},
        '{'{31'd1, 31'h4000_0000}, 1'b0, '{31'd0, ST_OK}},
        '{'{31'h2AAA_AAAA, 31'h5555_5555}, 1'b0, '{31'd0, ST_OK}},
        '{'{31'h5555_5555, Q31_MAX}, 1'b0, '{31'd0, ST_OK}},
        '{'{31'h0000_0FFF, 31'h0000_1000}, 1'b0, '{31'd0, ST_OK}},
        '{'{31'd3, 31'd5}, 1'b0, '{31'd0, ST_OK}},
        '{'{31'h1234_5678, 31'h7654_321F}, 1'b0, '{31'd0, ST_OK}},
        '{'{31'h4000_0000, Q31_MAX}, 1'b0, '{31'd0, ST_OK}},
        '{'{31'd0, 31'h4000_0000}, 1'b0, '{31'd0, ST_OK}}
    };

    q31_newton_raphson_divider #(
        .REFINE_STEPS(REFINE_PASSES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint clamp_s32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Q29 product, rounded half up; the arithmetic shift floors negative values.
    function automatic longint round_q29_product(input longint a, input longint b);
        return (a * b + 64'sd268435456) >>> 29;
    endfunction

    function automatic t_out divide_q31(input t_in op);
        logic [30:0] num;
        logic [30:0] den;
        longint      d;
        longint      n;
        longint      x;
        longint      e;
        longint      r;
        t_out        res;
        num = op.numerator;
        den = op.denominator;
        res.quotient = '0;
        res.status = ST_OK;
        if (num > den) begin
            res.status = ST_NUM_GT;
        end else if (den == '0) begin
            res.status = ST_DIV_ZERO;
        end else if (num == den) begin
            res.quotient = Q31_MAX;
        end else begin
            while (!den[30]) begin
                den = den << 1;
                num = num << 1;
            end
            d = den >> 2;
            n = num >> 2;
            x = clamp_s32(RECIP_OFFSET - round_q29_product(RECIP_SLOPE, d));
            x = clamp_s32(x * 4);
            for (int k = 0; k < REFINE_PASSES; k++) begin
                e = clamp_s32(UNITY_Q29 - round_q29_product(d, x));
                x = clamp_s32(x + round_q29_product(x, e));
            end
            r = (n * x + 64'sd67108864) >>> 27;
            if (r < 0) begin
                r = 0;
            end
            if (r > longint'(Q31_MAX)) begin
                r = longint'(Q31_MAX);
            end
            res.quotient = 31'(r);
        end
        return res;
    endfunction

    // Mostly proper fractions of every magnitude, so that the reciprocal path
    // and every normalization shift are exercised; the rest hits the early exits or is random.
    function automatic t_in random_division();
        t_in op;
        int  kind;
        kind = $urandom_range(99);
        op.denominator = 31'($urandom() >> $urandom_range(31, 1));
        op.numerator = 31'($urandom());
        if (kind < 72) begin
            if (op.denominator == '0) begin
                op.denominator = 31'd1;
            end
            op.numerator = 31'($urandom_range(32'(op.denominator) - 1, 0));
            if ($urandom_range(3) == 0) begin
                op.numerator = op.numerator >> $urandom_range(30, 1);
            end
        end else if (kind < 82) begin
            op.numerator = op.denominator;
        end else if (kind < 92) begin
            if (op.denominator == Q31_MAX) begin
                op.denominator = Q31_MAX - 31'd1;
            end
            op.numerator = 31'($urandom_range(32'h7FFF_FFFF, 32'(op.denominator) + 1));
        end else if (kind < 96) begin
            op.denominator = '0;
            if ($urandom_range(1) == 0) begin
                op.numerator = '0;
            end
        end else begin
            op.denominator = 31'($urandom());
        end
        return op;
    endfunction

    task automatic send_division(input t_in op, input t_out res);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= op;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        quot_expected.push_back(res);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (quot_expected.size() == 0) begin
                $error("unexpected transfer: quotient %h status %0d",
                       o_out_data.quotient, o_out_data.status);
                mismatches++;
            end else begin
                quot_head = quot_expected.pop_front();
                if (o_out_data.quotient !== quot_head.quotient) begin
                    $error("quotient: expected %h, actual %h",
                           quot_head.quotient, o_out_data.quotient);
                    mismatches++;
                end
                if (o_out_data.status !== quot_head.status) begin
                    $error("status: expected %0d, actual %0d",
                           quot_head.status, o_out_data.status);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_in op;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_division(directed_rows[i].op, directed_rows[i].known ?
                          directed_rows[i].res : divide_q31(directed_rows[i].op));
        end

        for (int p = 0; p < 4; p++) begin
            idle_pct  = IDLE_PLAN[p];
            stall_pct = STALL_PLAN[p];
            repeat (PHASE_ITEMS) begin
                op = random_division();
                send_division(op, divide_q31(op));
            end
        end

        // The output is held off while the input keeps offering transfers.
        idle_pct  = 0;
        stall_pct = 0;
        hold_requests++;
        repeat (PRESSURE_ITEMS) begin
            op = random_division();
            send_division(op, divide_q31(op));
        end
        i_in_valid <= 1'b0;

        while (quot_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/q31nr_pkg.sv
sv/q31_newton_raphson_divider.sv
tb/q31_newton_raphson_divider_test.sv
